@@ rtl/cluster_color_map_top_defines.svh @@
// assertion macros used by the checker file
`ifndef CLUSTER_COLOR_MAP_TOP_DEFINES_SVH
`define CLUSTER_COLOR_MAP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccm check failed");

// next-cycle implication, sampled on clk, off during reset
`define CCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccm check failed");

`endif

@@ rtl/ccm_pkg.sv @@
// types, constants and mapping functions for the color map
package ccm_pkg;

  localparam int unsigned FracWidth = 18;
  localparam int unsigned ChanWidth = 8;
  localparam int unsigned ColorWidth = 24;

  localparam logic [16:0] OneFx = 17'h10000;

  // rainbow segments, taken from the integer part of 5*x+1
  localparam logic [2:0] SegMagentaBlue = 3'd1;
  localparam logic [2:0] SegBlueCyan = 3'd2;
  localparam logic [2:0] SegCyanGreen = 3'd3;
  localparam logic [2:0] SegGreenYellow = 3'd4;

  typedef enum logic [1:0] {
    RegUseRainbow = 2'd0,
    RegMinColor   = 2'd1,
    RegMaxColor   = 2'd2
  } ccm_reg_t;

  typedef struct packed {
    logic                  use_rainbow;
    logic [ColorWidth-1:0] start_color;
    logic [ColorWidth-1:0] end_color;
  } ccm_cfg_t;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } ccm_rgb_t;

  function automatic ccm_rgb_t rainbow_map(logic signed [FracWidth-1:0] x);
    logic [16:0] xc;
    logic [18:0] h;
    logic [2:0]  seg;
    logic [15:0] f;
    logic [16:0] n;
    logic [24:0] s;
    logic [7:0]  v;
    ccm_rgb_t    rgb;
    if (x < 0) begin
      xc = '0;
    end else if (x > $signed({1'b0, OneFx})) begin
      xc = OneFx;
    end else begin
      xc = x[16:0];
    end
    h = {xc, 2'b00} + {2'b00, xc} + {2'b00, OneFx};
    seg = h[18:16];
    f = h[15:0];
    // odd segments fall, even segments rise
    n = seg[0] ? (OneFx - {1'b0, f}) : {1'b0, f};
    s = {n, 8'h00} - {8'h00, n} + 25'h0008000;
    v = s[23:16];
    case (seg) inside
      [3'd0:SegMagentaBlue]: begin
        rgb = '{red: v, green: 8'd0, blue: 8'd255};
      end
      SegBlueCyan: begin
        rgb = '{red: 8'd0, green: v, blue: 8'd255};
      end
      SegCyanGreen: begin
        rgb = '{red: 8'd0, green: 8'd255, blue: v};
      end
      SegGreenYellow: begin
        rgb = '{red: v, green: 8'd255, blue: 8'd0};
      end
      default: begin
        rgb = '{red: 8'd255, green: v, blue: 8'd0};
      end
    endcase
    return rgb;
  endfunction

  function automatic logic [ChanWidth-1:0] blend_chan(logic signed [FracWidth-1:0] x,
                                                      logic [ChanWidth-1:0] lo,
                                                      logic [ChanWidth-1:0] hi);
    logic signed [8:0]  d;
    logic signed [26:0] prod;
    logic signed [26:0] v;
    logic signed [26:0] r;
    logic [ChanWidth-1:0] res;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod = 27'(x) * 27'(d);
    v = prod + $signed({3'b000, lo, 16'h0000});
    r = (v + 27'sd32768) >>> 16;
    if (v < 0) begin
      res = '0;
    end else if (r > 27'sd255) begin
      res = 8'd255;
    end else begin
      res = r[7:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/cluster_color_map_top.sv @@
// cluster color map: input register, mapping logic, result register
// an accepted input word passes through the input register, then the result register
// throughput: one word per cycle; the only limit is the output stall
// the two registers form a stalling pipeline, in_stall is high only when both are full
// reset (rst, synchronous) empties both stages and loads use_rainbow=1,
// start_color=0xffffff, end_color=0
module cluster_color_map_top
  import ccm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [FracWidth-1:0] fraction,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ChanWidth-1:0]        red,
  output logic [ChanWidth-1:0]        green,
  output logic [ChanWidth-1:0]        blue,
  input  logic                        cfg_write_en,
  input  logic [1:0]                  cfg_index,
  input  logic [ColorWidth-1:0]       cfg_data
);

  ccm_cfg_t                    cfg;
  logic                        s1_valid;
  logic signed [FracWidth-1:0] s1_fraction;
  logic                        out_free;
  ccm_rgb_t                    map_rgb;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_rainbow <= 1'b1;
      cfg.start_color <= 24'hffffff;
      cfg.end_color   <= 24'h000000;
    end else if (cfg_write_en) begin
      case (cfg_index)
        RegUseRainbow: cfg.use_rainbow <= cfg_data[0];
        RegMinColor:   cfg.start_color <= cfg_data;
        RegMaxColor:   cfg.end_color <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_fraction <= fraction;
    end
    if (out_free && s1_valid) begin
      red   <= map_rgb.red;
      green <= map_rgb.green;
      blue  <= map_rgb.blue;
    end
  end

  ccm_map u_map (
    .cfg      (cfg),
    .fraction (s1_fraction),
    .rgb      (map_rgb)
  );

endmodule

@@ rtl/ccm_map.sv @@
// combinational color mapping: rainbow or min/max blend
module ccm_map
  import ccm_pkg::*;
(
  input  ccm_cfg_t                     cfg,
  input  logic signed [FracWidth-1:0]  fraction,
  output ccm_rgb_t                     rgb
);

  ccm_rgb_t rainbow_rgb;
  ccm_rgb_t blend_rgb;

  always_comb begin
    rainbow_rgb = rainbow_map(fraction);
    blend_rgb.red   = blend_chan(fraction, cfg.start_color[23:16], cfg.end_color[23:16]);
    blend_rgb.green = blend_chan(fraction, cfg.start_color[15:8], cfg.end_color[15:8]);
    blend_rgb.blue  = blend_chan(fraction, cfg.start_color[7:0], cfg.end_color[7:0]);
    rgb = cfg.use_rainbow ? rainbow_rgb : blend_rgb;
  end

endmodule

@@ rtl/ccm_checker.sv @@
// port-level checks for the color map, bound to the top level
`include "cluster_color_map_top_defines.svh"

module ccm_checker
  import ccm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [ChanWidth-1:0] red,
  input logic [ChanWidth-1:0] green,
  input logic [ChanWidth-1:0] blue
);

  // input backs up only when the result word is held and the stage behind it is full
  `CCM_ASSERT_NOW(a_stall_needs_full, in_stall, out_valid && out_stall)

  // an accepted word moves on from the input register into the result register unless a held word stalls
  `CCM_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid)

  `CCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  `CCM_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                   $stable(red) && $stable(green) && $stable(blue))

endmodule

bind cluster_color_map_top ccm_checker u_ccm_checker (.*);

@@ tb/tb_cluster_color_map_top.sv @@
// testbench for the cluster color map: random and corner fractions checked against a predictor
module tb_cluster_color_map_top
  import ccm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FxOne = 65536;
  localparam int FxHalf = 32768;
  localparam int NumPhases = 12;
  localparam int RandomPerPhase = 112;
  localparam int WatchLimit = 2000;
  localparam int TailCycles = 6;
  // index past the register list, writes there must be dropped
  localparam logic [1:0] RegUnused = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [FracWidth-1:0] fraction = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [ChanWidth-1:0]        red;
  logic [ChanWidth-1:0]        green;
  logic [ChanWidth-1:0]        blue;
  logic                        cfg_write_en = 1'b0;
  logic [1:0]                  cfg_index = '0;
  logic [ColorWidth-1:0]       cfg_data = '0;

  logic signed [FracWidth-1:0] pending_fractions[$];
  ccm_rgb_t                    expected_colors[$];
  ccm_cfg_t                    shadow_cfg = '{use_rainbow: 1'b1, start_color: 24'hffffff,
                                              end_color: 24'h000000};
  int                          send_idle_pct = 0;
  int                          stall_pct = 0;
  int                          mismatches = 0;
  int                          quiet_cycles = 0;

  // segment knees sit at multiples of 0.2
  logic signed [FracWidth-1:0] rainbow_pts[17] = '{18'h20000, 18'h3ffff, 0, 1, 13107, 13108,
                                                   26214, 26215, 39321, 39322, 52428, 52429,
                                                   32768, 65535, 65536, 65537, 131071};
  logic signed [FracWidth-1:0] blend_pts[8] = '{0, 65536, 18'h3ffff, 18'h20000, 131071,
                                                32768, 1, 65535};

  cluster_color_map_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .fraction(fraction),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic ccm_rgb_t rainbow_color(int x);
    int unsigned xc;
    int unsigned h;
    int unsigned seg;
    int unsigned f;
    int unsigned lvl;
    logic [7:0]  v;
    ccm_rgb_t    c;
    xc = (x < 0) ? 0 : ((x > FxOne) ? FxOne : x);
    h = xc * 5 + FxOne;
    seg = h >> 16;
    f = h & 32'hffff;
    // even segments run the remainder backwards
    if (seg % 2 == 0) f = FxOne - f;
    lvl = FxOne - f;
    v = 8'((lvl * 255 + FxHalf) >> 16);
    if (seg <= SegMagentaBlue) c = '{red: v, green: 8'd0, blue: 8'd255};
    else if (seg == SegBlueCyan) c = '{red: 8'd0, green: v, blue: 8'd255};
    else if (seg == SegCyanGreen) c = '{red: 8'd0, green: 8'd255, blue: v};
    else if (seg == SegGreenYellow) c = '{red: v, green: 8'd255, blue: 8'd0};
    else c = '{red: 8'd255, green: v, blue: 8'd0};
    return c;
  endfunction

  function automatic logic [7:0] blend_byte(int x, logic [7:0] lo, logic [7:0] hi);
    longint acc;
    acc = longint'(lo) * FxOne + longint'(x) * (longint'(hi) - longint'(lo));
    if (acc < 0) return 8'd0;
    acc = (acc + FxHalf) >>> 16;
    if (acc > 255) return 8'd255;
    return acc[7:0];
  endfunction

  function automatic ccm_rgb_t predict_color(logic signed [FracWidth-1:0] frac);
    int       x;
    ccm_rgb_t c;
    x = frac;
    if (shadow_cfg.use_rainbow) begin
      c = rainbow_color(x);
    end else begin
      c.red = blend_byte(x, shadow_cfg.start_color[23:16], shadow_cfg.end_color[23:16]);
      c.green = blend_byte(x, shadow_cfg.start_color[15:8], shadow_cfg.end_color[15:8]);
      c.blue = blend_byte(x, shadow_cfg.start_color[7:0], shadow_cfg.end_color[7:0]);
    end
    return c;
  endfunction

  function automatic logic signed [FracWidth-1:0] pick_fraction();
    int unsigned sel;
    int          k;
    sel = $urandom_range(99);
    if (sel < 55) return FracWidth'($urandom_range(FxOne));
    if (sel < 80) return FracWidth'($urandom());
    if (sel < 92) begin
      k = $urandom_range(5);
      return FracWidth'(k * FxOne / 5 + int'($urandom_range(6)) - 3);
    end
    case ($urandom_range(4))
      0: return 18'h20000;
      1: return 18'h1ffff;
      2: return 18'h3ffff;
      3: return 18'h10000;
      default: return 18'h00000;
    endcase
  endfunction

  // each channel at an end of its range or anywhere in it
  function automatic logic [ColorWidth-1:0] pick_color();
    logic [ColorWidth-1:0] c;
    for (int b = 0; b < 3; b++) begin
      case ($urandom_range(3))
        0: c[b*8 +: 8] = 8'd0;
        1: c[b*8 +: 8] = 8'd255;
        default: c[b*8 +: 8] = 8'($urandom());
      endcase
    end
    return c;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [ColorWidth-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      RegUseRainbow: shadow_cfg.use_rainbow = data[0];
      RegMinColor: shadow_cfg.start_color = data;
      RegMaxColor: shadow_cfg.end_color = data;
      default: ;
    endcase
  endtask

  task automatic setup_phase(int p);
    case (p % 4)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 61; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 61; end
      default: begin send_idle_pct = 7; stall_pct = 7; end
    endcase
    case (p)
      0: ;
      1: write_reg(RegUseRainbow, {23'($urandom()), 1'b0});
      2: begin
        write_reg(RegMinColor, 24'h000000);
        write_reg(RegMaxColor, 24'hffffff);
      end
      3: begin
        write_reg(RegMinColor, pick_color());
        write_reg(RegMaxColor, pick_color());
      end
      4: begin
        write_reg(RegMinColor, 24'hff00ff);
        write_reg(RegMaxColor, 24'h00ff00);
      end
      5: begin
        write_reg(RegUseRainbow, {23'($urandom()), 1'b1});
        write_reg(RegUnused, 24'($urandom()));
      end
      6: begin
        write_reg(RegUseRainbow, {23'($urandom()), 1'b0});
        write_reg(RegMinColor, 24'h5a3c96);
        write_reg(RegMaxColor, 24'h5a3c96);
      end
      default: begin
        write_reg(RegUseRainbow, 24'($urandom()));
        write_reg(RegMinColor, pick_color());
        write_reg(RegMaxColor, pick_color());
        if ($urandom_range(1)) write_reg(RegUnused, 24'($urandom()));
      end
    endcase
  endtask

  // look between edges so the driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_fractions.size() != 0 || in_valid || expected_colors.size() != 0);
  endtask

  task automatic check_chan(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // sender: holds a stalled word, otherwise may take a new one or go idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_fractions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        fraction <= pending_fractions.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    ccm_rgb_t want;
    if (!rst && in_valid && !in_stall) expected_colors.push_back(predict_color(fraction));
    if (!rst && out_valid && !out_stall) begin
      if (expected_colors.size() == 0) begin
        $error("color word %0d/%0d/%0d with nothing pending", red, green, blue);
        mismatches++;
      end else begin
        want = expected_colors.pop_front();
        check_chan("red", want.red, red);
        check_chan("green", want.green, green);
        check_chan("blue", want.blue, blue);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("tb_cluster_color_map_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NumPhases; p++) begin
      setup_phase(p);
      if (p == 0) foreach (rainbow_pts[i]) pending_fractions.push_back(rainbow_pts[i]);
      if (p == 1) foreach (blend_pts[i]) pending_fractions.push_back(blend_pts[i]);
      repeat (RandomPerPhase) pending_fractions.push_back(pick_fraction());
      wait_drained();
    end
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_cluster_color_map_top OK");
    end else begin
      $display("tb_cluster_color_map_top NOT OK");
    end
    $finish;
  end

endmodule
